FILE: rtl/i2cmbc_pkg.sv
// Shared types and constants of the I2C master byte controller.
package i2cmbc_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_CNT_W     = 4;
  localparam int unsigned TIMER_W       = 11;

  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_STOP    = 3'd2;
  localparam logic [2:0] OP_WRITE   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_WAITACK = 3'd5;

  localparam logic REG_TICKS = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [7:0] TICKS_RESET = 8'd100;
  localparam logic [7:0] LIMIT_RESET = 8'd250;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_START_A = 4'd1,
    ST_START_B = 4'd2,
    ST_STOP_A  = 4'd3,
    ST_STOP_B  = 4'd4,
    ST_WR_DATA = 4'd5,
    ST_WR_HIGH = 4'd6,
    ST_WR_LOW  = 4'd7,
    ST_RD_LOW  = 4'd8,
    ST_RD_HIGH = 4'd9,
    ST_ACK_LOW = 4'd10,
    ST_ACK_HIGH = 4'd11,
    ST_WA_REL  = 4'd12,
    ST_WA_HIGH = 4'd13,
    ST_WA_POLL = 4'd14
  } step_e;

  typedef struct packed {
    logic [7:0] ticks;
    logic [7:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_drive;
    logic       sda_level;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_timeout;
  } res_t;

  typedef struct packed {
    step_e                step;
    logic [2:0]           cmd;
    logic [TIMER_W-1:0]   timer;
    logic [BIT_CNT_W-1:0] bitc;
    logic [7:0]           shreg;
    logic [7:0]           poll;
    logic                 ack_sel;
    logic                 scl;
    logic                 drv;
    logic                 lvl;
    logic [7:0]           rxb;
    logic                 tflag;
  } seq_state_t;

endpackage

FILE: rtl/i2cmbc_cfg.sv
// APB configuration registers: delay unit and acknowledge poll limit.
module i2cmbc_cfg
  import i2cmbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [7:0] ticks_q;
  logic [7:0] limit_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= TICKS_RESET;
      limit_q <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_TICKS: ticks_q <= pwdata[7:0];
        REG_LIMIT: limit_q <= pwdata[7:0];
        default:   ticks_q <= ticks_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TICKS: prdata = {24'd0, ticks_q};
      REG_LIMIT: prdata = {24'd0, limit_q};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg_o.ticks = ticks_q;
  assign cfg_o.limit = limit_q;

endmodule

FILE: rtl/i2cmbc_seq.sv
// Line sequencer: one tick of SCL/SDA stepping per accepted word.
module i2cmbc_seq
  import i2cmbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  seq_state_t st_q, st_d;
  logic       done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.step    <= ST_IDLE;
      st_q.cmd     <= OP_NONE;
      st_q.timer   <= '0;
      st_q.bitc    <= '0;
      st_q.shreg   <= '0;
      st_q.poll    <= '0;
      st_q.ack_sel <= 1'b0;
      st_q.scl     <= 1'b1;
      st_q.drv     <= 1'b0;
      st_q.lvl     <= 1'b1;
      st_q.rxb     <= '0;
      st_q.tflag   <= 1'b0;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    seq_state_t         s;
    logic [7:0]         u;
    logic [TIMER_W-1:0] u1, u2, u4;
    logic               do_poll;
    s       = st_q;
    done    = 1'b0;
    do_poll = 1'b0;
    u       = (cfg_i.ticks == 8'd0) ? 8'd1 : cfg_i.ticks;
    u1      = {3'b000, u};
    u2      = {2'b00, u, 1'b0};
    u4      = {1'b0, u, 2'b00};
    if (en_i) begin
      if (s.step == ST_IDLE) begin
        if (item_i.op >= OP_START && item_i.op <= OP_WAITACK) begin
          s.cmd  = item_i.op;
          s.bitc = '0;
          s.poll = '0;
          unique case (item_i.op)
            OP_START: begin
              s.drv = 1'b1; s.lvl = 1'b1; s.scl = 1'b1;
              s.step = ST_START_A; s.timer = u4;
            end
            OP_STOP: begin
              s.drv = 1'b1; s.scl = 1'b0; s.lvl = 1'b0;
              s.step = ST_STOP_A; s.timer = u4;
            end
            OP_WRITE: begin
              s.drv = 1'b1; s.scl = 1'b0;
              s.lvl = item_i.tx_byte[7];
              s.shreg = {item_i.tx_byte[6:0], 1'b0};
              s.step = ST_WR_DATA; s.timer = u2;
            end
            OP_READ: begin
              s.ack_sel = item_i.send_ack; s.shreg = '0;
              s.drv = 1'b0; s.lvl = 1'b1; s.scl = 1'b0;
              s.step = ST_RD_LOW; s.timer = u2;
            end
            default: begin
              s.drv = 1'b0; s.lvl = 1'b1;
              s.step = ST_WA_REL; s.timer = u1;
            end
          endcase
        end
      end else if (s.step == ST_WA_POLL) begin
        do_poll = 1'b1;
      end else if (s.timer > TIMER_W'(1)) begin
        s.timer = s.timer - TIMER_W'(1);
      end else begin
        s.timer = '0;
        unique case (s.step)
          ST_START_A: begin
            s.lvl = 1'b0; s.step = ST_START_B; s.timer = u4;
          end
          ST_START_B: begin
            s.scl = 1'b0; s.step = ST_IDLE; done = 1'b1;
          end
          ST_STOP_A: begin
            s.scl = 1'b1; s.lvl = 1'b1; s.step = ST_STOP_B; s.timer = u4;
          end
          ST_STOP_B: begin
            if (s.cmd == OP_WAITACK) s.tflag = 1'b1;
            s.step = ST_IDLE; done = 1'b1;
          end
          ST_WR_DATA: begin
            s.scl = 1'b1; s.step = ST_WR_HIGH; s.timer = u2;
          end
          ST_WR_HIGH: begin
            s.scl = 1'b0; s.step = ST_WR_LOW; s.timer = u2;
          end
          ST_WR_LOW: begin
            s.bitc = s.bitc + BIT_CNT_W'(1);
            if (s.bitc < BIT_CNT_W'(BITS_PER_BYTE)) begin
              s.lvl   = s.shreg[7];
              s.shreg = {s.shreg[6:0], 1'b0};
              s.step  = ST_WR_DATA; s.timer = u2;
            end else begin
              s.step = ST_IDLE; done = 1'b1;
            end
          end
          ST_RD_LOW: begin
            s.scl   = 1'b1;
            s.shreg = {s.shreg[6:0], item_i.sda_in};
            s.step  = ST_RD_HIGH; s.timer = u1;
          end
          ST_RD_HIGH: begin
            s.bitc = s.bitc + BIT_CNT_W'(1);
            s.scl  = 1'b0;
            if (s.bitc < BIT_CNT_W'(BITS_PER_BYTE)) begin
              s.step = ST_RD_LOW; s.timer = u2;
            end else begin
              s.drv  = 1'b1;
              s.lvl  = !s.ack_sel;
              s.step = ST_ACK_LOW; s.timer = u2;
            end
          end
          ST_ACK_LOW: begin
            s.scl = 1'b1; s.step = ST_ACK_HIGH; s.timer = u2;
          end
          ST_ACK_HIGH: begin
            s.scl = 1'b0; s.rxb = s.shreg; s.step = ST_IDLE; done = 1'b1;
          end
          ST_WA_REL: begin
            s.scl = 1'b1; s.step = ST_WA_HIGH; s.timer = u1;
          end
          ST_WA_HIGH: begin
            s.step = ST_WA_POLL; do_poll = 1'b1;
          end
          default: begin
            s.step = ST_IDLE;
          end
        endcase
      end
      if (do_poll) begin
        if (!item_i.sda_in) begin
          s.scl = 1'b0; s.tflag = 1'b0; s.step = ST_IDLE; done = 1'b1;
        end else if (s.poll >= cfg_i.limit) begin
          s.drv = 1'b1; s.scl = 1'b0; s.lvl = 1'b0;
          s.step = ST_STOP_A; s.timer = u4;
        end else begin
          s.poll = s.poll + 8'd1;
        end
      end
    end
    st_d = s;
  end

  assign res_o.scl         = st_d.scl;
  assign res_o.sda_drive   = st_d.drv;
  assign res_o.sda_level   = st_d.drv ? st_d.lvl : 1'b1;
  assign res_o.busy        = (st_d.step != ST_IDLE);
  assign res_o.done        = done;
  assign res_o.rx_byte     = st_d.rxb;
  assign res_o.ack_timeout = st_d.tflag;

endmodule

FILE: rtl/i2c_master_byte_controller.sv
// Top level of the tick-driven I2C master: input register, sequencer, result register.
//
//   channel | handshake                  | payload
//   in      | in_valid_i / in_ready_o    | opcode_i tx_byte_i send_ack_i sda_in_i
//   out     | out_valid_o / out_ready_i  | scl_o sda_drive_o sda_level_o busy_res_o
//           |                            | done_res_o rx_byte_o ack_timeout_o
//   cfg     | psel penable pwrite pready | paddr pwdata prdata
//
// One word per cycle unless the result register stalls; the input register feeds it.
// The sequencer state advances as a word moves from the input to the result register.
// Reset (rst_ni low) empties both registers; sequencer resets to SCL high, SDA released.
// A stalled result holds; the input register keeps filling until both are full.
module i2c_master_byte_controller
  import i2cmbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        send_ack_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_o,
  output logic        sda_drive_o,
  output logic        sda_level_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic        ack_timeout_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  item_t item_q;
  logic  in_valid_q;
  logic  out_valid_q;
  res_t  res_d, res_q;
  logic  step_en;

  assign step_en    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (step_en) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.op       <= opcode_i;
      item_q.tx_byte  <= tx_byte_i;
      item_q.send_ack <= send_ack_i;
      item_q.sda_in   <= sda_in_i;
    end
    if (step_en) res_q <= res_d;
  end

  i2cmbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2cmbc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step_en),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  assign out_valid_o   = out_valid_q;
  assign scl_o         = res_q.scl;
  assign sda_drive_o   = res_q.sda_drive;
  assign sda_level_o   = res_q.sda_level;
  assign busy_res_o    = res_q.busy;
  assign done_res_o    = res_q.done;
  assign rx_byte_o     = res_q.rx_byte;
  assign ack_timeout_o = res_q.ack_timeout;

endmodule

FILE: rtl/i2cmbc_chk.sv
// Port checker of the I2C master byte controller and its bind.
module i2cmbc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        scl_o,
  input logic        sda_drive_o,
  input logic        sda_level_o,
  input logic        busy_res_o,
  input logic        done_res_o,
  input logic [7:0]  rx_byte_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rx_byte_o) && $stable(scl_o)
      && $stable(done_res_o) && $stable(busy_res_o))
    else $error("stalled result word changed");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done pulse while still busy");

  a_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sda_drive_o |-> sda_level_o)
    else $error("released SDA not shown high");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i || !out_valid_o |-> in_ready_o)
    else $error("input stalled with room downstream");

endmodule

bind i2c_master_byte_controller i2cmbc_chk u_chk (.*);

FILE: dv/tb.sv
// Self-checking testbench of the tick-driven I2C master byte controller.
`timescale 1ns / 100ps

module tb
  import i2cmbc_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  logic [2:0]  opcode;
  logic [7:0]  tx_byte;
  logic        send_ack;
  logic        sda_in;
  logic        out_valid_o;
  logic        out_ready;
  logic        scl_o;
  logic        sda_drive_o;
  logic        sda_level_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  rx_byte_o;
  logic        ack_timeout_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_byte_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode),
    .tx_byte_i     (tx_byte),
    .send_ack_i    (send_ack),
    .sda_in_i      (sda_in),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .scl_o         (scl_o),
    .sda_drive_o   (sda_drive_o),
    .sda_level_o   (sda_level_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .rx_byte_o     (rx_byte_o),
    .ack_timeout_o (ack_timeout_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  seq_state_t ctl;
  cfg_t       regs;
  res_t       line_states_q[$];

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned results_seen;
  bit          send_gaps_on;
  bit          recv_gaps_on;
  int          hold_cycles;
  int          ack_odds;
  int          line_level_mode;
  int          bus_phase;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void load_wait(step_e s, int units);
    logic [7:0] u;
    u = (regs.ticks == 8'd0) ? 8'd1 : regs.ticks;
    ctl.step  = s;
    ctl.timer = TIMER_W'(units * u);
  endfunction

  function automatic void begin_stop();
    ctl.drv = 1'b1;
    ctl.scl = 1'b0;
    ctl.lvl = 1'b0;
    load_wait(ST_STOP_A, 4);
  endfunction

  function automatic void shift_out_bit();
    ctl.lvl   = ctl.shreg[7];
    ctl.shreg = {ctl.shreg[6:0], 1'b0};
    load_wait(ST_WR_DATA, 2);
  endfunction

  function automatic bit poll_sda(logic sda);
    if (!sda) begin
      ctl.scl   = 1'b0;
      ctl.tflag = 1'b0;
      ctl.step  = ST_IDLE;
      return 1'b1;
    end
    if (ctl.poll >= regs.limit) begin
      begin_stop();
    end else begin
      ctl.poll = ctl.poll + 8'd1;
    end
    return 1'b0;
  endfunction

  function automatic bit wait_expired(logic sda);
    case (ctl.step)
      ST_START_A: begin
        ctl.lvl = 1'b0;
        load_wait(ST_START_B, 4);
      end
      ST_START_B: begin
        ctl.scl  = 1'b0;
        ctl.step = ST_IDLE;
        return 1'b1;
      end
      ST_STOP_A: begin
        ctl.scl = 1'b1;
        ctl.lvl = 1'b1;
        load_wait(ST_STOP_B, 4);
      end
      ST_STOP_B: begin
        if (ctl.cmd == OP_WAITACK) ctl.tflag = 1'b1;
        ctl.step = ST_IDLE;
        return 1'b1;
      end
      ST_WR_DATA: begin
        ctl.scl = 1'b1;
        load_wait(ST_WR_HIGH, 2);
      end
      ST_WR_HIGH: begin
        ctl.scl = 1'b0;
        load_wait(ST_WR_LOW, 2);
      end
      ST_WR_LOW: begin
        ctl.bitc = ctl.bitc + BIT_CNT_W'(1);
        if (ctl.bitc < BITS_PER_BYTE) begin
          shift_out_bit();
          return 1'b0;
        end
        ctl.step = ST_IDLE;
        return 1'b1;
      end
      ST_RD_LOW: begin
        ctl.scl   = 1'b1;
        ctl.shreg = {ctl.shreg[6:0], sda};
        load_wait(ST_RD_HIGH, 1);
      end
      ST_RD_HIGH: begin
        ctl.bitc = ctl.bitc + BIT_CNT_W'(1);
        ctl.scl  = 1'b0;
        if (ctl.bitc < BITS_PER_BYTE) begin
          load_wait(ST_RD_LOW, 2);
          return 1'b0;
        end
        ctl.drv = 1'b1;
        ctl.lvl = ctl.ack_sel ? 1'b0 : 1'b1;
        load_wait(ST_ACK_LOW, 2);
      end
      ST_ACK_LOW: begin
        ctl.scl = 1'b1;
        load_wait(ST_ACK_HIGH, 2);
      end
      ST_ACK_HIGH: begin
        ctl.scl  = 1'b0;
        ctl.rxb  = ctl.shreg;
        ctl.step = ST_IDLE;
        return 1'b1;
      end
      ST_WA_REL: begin
        ctl.scl = 1'b1;
        load_wait(ST_WA_HIGH, 1);
      end
      ST_WA_HIGH: begin
        ctl.step = ST_WA_POLL;
        return poll_sda(sda);
      end
      default: ctl.step = ST_IDLE;
    endcase
    return 1'b0;
  endfunction

  function automatic void start_command(logic [2:0] op, logic [7:0] tx, logic ack);
    ctl.cmd  = op;
    ctl.bitc = '0;
    ctl.poll = '0;
    case (op)
      OP_START: begin
        ctl.drv = 1'b1;
        ctl.lvl = 1'b1;
        ctl.scl = 1'b1;
        load_wait(ST_START_A, 4);
      end
      OP_STOP: begin_stop();
      OP_WRITE: begin
        ctl.drv   = 1'b1;
        ctl.scl   = 1'b0;
        ctl.shreg = tx;
        shift_out_bit();
      end
      OP_READ: begin
        ctl.ack_sel = ack;
        ctl.shreg   = '0;
        ctl.drv     = 1'b0;
        ctl.lvl     = 1'b1;
        ctl.scl     = 1'b0;
        load_wait(ST_RD_LOW, 2);
      end
      default: begin
        ctl.drv = 1'b0;
        ctl.lvl = 1'b1;
        load_wait(ST_WA_REL, 1);
      end
    endcase
  endfunction

  function automatic res_t step_sequencer(item_t w);
    res_t r;
    bit   fin;
    fin = 1'b0;
    if (ctl.step == ST_IDLE) begin
      if (w.op >= OP_START && w.op <= OP_WAITACK) start_command(w.op, w.tx_byte, w.send_ack);
    end else if (ctl.step == ST_WA_POLL) begin
      fin = poll_sda(w.sda_in);
    end else if (ctl.timer > TIMER_W'(1)) begin
      ctl.timer = ctl.timer - TIMER_W'(1);
    end else begin
      ctl.timer = '0;
      fin = wait_expired(w.sda_in);
    end
    r.scl         = ctl.scl;
    r.sda_drive   = ctl.drv;
    r.sda_level   = ctl.drv ? ctl.lvl : 1'b1;
    r.busy        = (ctl.step != ST_IDLE);
    r.done        = fin;
    r.rx_byte     = ctl.rxb;
    r.ack_timeout = ctl.tflag;
    return r;
  endfunction

  function automatic logic pick_sda();
    if (ctl.step == ST_WA_REL || ctl.step == ST_WA_HIGH || ctl.step == ST_WA_POLL) begin
      if (ack_odds < 0) return 1'b1;
      return ($urandom_range(0, ack_odds) == 0) ? 1'b0 : 1'b1;
    end
    if (line_level_mode == 2) return 1'($urandom_range(0, 1));
    return line_level_mode[0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40) begin
      $display("MISMATCH word %0d %s: got %0h want %0h", results_seen, what, got, want);
    end
    mismatches++;
  endtask

  task automatic send_word(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                           input logic sda);
    int    gap;
    item_t w;
    gap = send_gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    opcode   <= op;
    tx_byte  <= tx;
    send_ack <= ack;
    sda_in   <= sda;
    do @(posedge clk_i); while (!in_ready_o);
    w.op       = op;
    w.tx_byte  = tx;
    w.send_ack = ack;
    w.sda_in   = sda;
    line_states_q.push_back(step_sequencer(w));
  endtask

  task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                         input bit noisy);
    send_word(op, tx, ack, pick_sda());
    while (ctl.step != ST_IDLE) begin
      send_word(noisy ? 3'($urandom_range(0, 7)) : OP_NONE, 8'($urandom),
                1'($urandom_range(0, 1)), pick_sda());
    end
  endtask

  task automatic wait_drained();
    while (ctl.step != ST_IDLE) send_word(OP_NONE, 8'($urandom), 1'b0, pick_sda());
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (line_states_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic idx, input logic [7:0] value);
    wait_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[7:0] !== value) report_mismatch("register readback", prdata[7:0], value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_TICKS) regs.ticks = value;
    else regs.limit = value;
  endtask

  task automatic read_reg(input logic idx, input logic [7:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[7:0] !== want) report_mismatch("register reset value", prdata[7:0], want);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_traffic(input int n);
    logic [2:0] op;
    int         r;
    for (int i = 0; i < n; i++) begin
      op = OP_NONE;
      r  = $urandom_range(0, 99);
      if (ctl.step != ST_IDLE) begin
        if (r < 20) op = 3'($urandom_range(0, 7));
      end else if (r < 10) begin
        op = 3'($urandom_range(0, 7));
      end else if (r < 25) begin
        op = OP_NONE;
      end else begin
        case (bus_phase)
          0: begin
            op = OP_START;
            bus_phase = 1;
          end
          1: begin
            op = OP_WRITE;
            bus_phase = 2;
          end
          2: begin
            op = OP_WAITACK;
            bus_phase = 3;
            r = $urandom_range(0, 99);
            ack_odds = (r < 15) ? -1 : $urandom_range(0, 3);
          end
          default: begin
            r = $urandom_range(0, 99);
            if (ctl.tflag || r < 30) begin
              op = OP_STOP;
              bus_phase = 0;
            end else if (r < 65) begin
              op = OP_WRITE;
              bus_phase = 2;
            end else begin
              op = OP_READ;
            end
          end
        endcase
      end
      send_word(op, 8'($urandom), 1'($urandom_range(0, 1)), pick_sda());
    end
  endtask

  task automatic test_reset_values();
    read_reg(REG_TICKS, TICKS_RESET);
    read_reg(REG_LIMIT, LIMIT_RESET);
    send_word(OP_NONE, 8'hFF, 1'b1, 1'b1);
    send_word(3'd6, 8'h00, 1'b0, 1'b0);
    send_word(3'd7, 8'h5A, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_directed();
    line_level_mode = 2;
    set_reg(REG_TICKS, 8'd1);
    set_reg(REG_LIMIT, 8'd2);
    run_cmd(OP_START, 8'h00, 1'b0, 1'b0);
    run_cmd(OP_WRITE, 8'hFF, 1'b0, 1'b1);
    ack_odds = 0;
    run_cmd(OP_WAITACK, 8'h00, 1'b0, 1'b0);
    run_cmd(OP_WRITE, 8'h00, 1'b1, 1'b1);
    ack_odds = -1;
    run_cmd(OP_WAITACK, 8'h00, 1'b0, 1'b0);
    run_cmd(OP_START, 8'h00, 1'b0, 1'b1);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, 1'b0);
    ack_odds = 3;
    run_cmd(OP_WAITACK, 8'h00, 1'b0, 1'b1);
    line_level_mode = 1;
    run_cmd(OP_READ, 8'h00, 1'b1, 1'b0);
    line_level_mode = 0;
    run_cmd(OP_READ, 8'hFF, 1'b0, 1'b1);
    line_level_mode = 2;
    run_cmd(OP_READ, 8'h3C, 1'b1, 1'b1);
    run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0);
    send_word(3'd6, 8'hFF, 1'b1, 1'b1);
    send_word(3'd7, 8'h00, 1'b0, 1'b0);
    send_word(OP_NONE, 8'h81, 1'b1, 1'b0);
    set_reg(REG_TICKS, 8'd0);
    set_reg(REG_LIMIT, 8'd0);
    run_cmd(OP_START, 8'h00, 1'b0, 1'b0);
    ack_odds = -1;
    run_cmd(OP_WAITACK, 8'h00, 1'b0, 1'b1);
    ack_odds = 0;
    run_cmd(OP_WAITACK, 8'h00, 1'b0, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_slow_timing();
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    set_reg(REG_TICKS, 8'd255);
    set_reg(REG_LIMIT, 8'd255);
    ack_odds = 0;
    run_cmd(OP_WAITACK, 8'h00, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [7:0] ticks_set[5];
    logic [7:0] limit_set[5];
    ticks_set = '{8'd1, 8'd2, 8'd1, 8'd3, 8'd0};
    limit_set = '{8'd1, 8'd3, 8'd255, 8'd6, 8'd0};
    line_level_mode = 2;
    for (int k = 0; k < 5; k++) begin
      set_reg(REG_TICKS, ticks_set[k]);
      set_reg(REG_LIMIT, limit_set[k]);
      send_gaps_on = (k % 3) != 0;
      recv_gaps_on = (k % 2) == 0;
      bus_phase = 0;
      run_traffic(100);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_reg(REG_TICKS, 8'd1);
    set_reg(REG_LIMIT, 8'd4);
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b1;
    hold_cycles  = 60;
    run_traffic(80);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (line_states_q.size() != 0) @(posedge clk_i);
    send_gaps_on = 1'b1;
    run_traffic(40);
    wait_drained();
  endtask

  initial begin : result_monitor
    int   gap;
    res_t got;
    res_t want;
    out_ready = 1'b0;
    forever begin
      gap = recv_gaps_on ? $urandom_range(0, 9) : 0;
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end
      if (gap > 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.scl         = scl_o;
      got.sda_drive   = sda_drive_o;
      got.sda_level   = sda_level_o;
      got.busy        = busy_res_o;
      got.done        = done_res_o;
      got.rx_byte     = rx_byte_o;
      got.ack_timeout = ack_timeout_o;
      if (line_states_q.size() == 0) begin
        report_mismatch("unexpected word", got, 0);
      end else begin
        want = line_states_q.pop_front();
        if (got.scl !== want.scl) report_mismatch("scl", got.scl, want.scl);
        if (got.sda_drive !== want.sda_drive)
          report_mismatch("sda_drive", got.sda_drive, want.sda_drive);
        if (got.sda_level !== want.sda_level)
          report_mismatch("sda_level", got.sda_level, want.sda_level);
        if (got.busy !== want.busy) report_mismatch("busy", got.busy, want.busy);
        if (got.done !== want.done) report_mismatch("done", got.done, want.done);
        if (got.rx_byte !== want.rx_byte) report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
        if (got.ack_timeout !== want.ack_timeout)
          report_mismatch("ack_timeout", got.ack_timeout, want.ack_timeout);
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid        = 1'b0;
    opcode          = OP_NONE;
    tx_byte         = '0;
    send_ack        = 1'b0;
    sda_in          = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mismatches      = 0;
    results_seen    = 0;
    send_gaps_on    = 1'b1;
    recv_gaps_on    = 1'b1;
    hold_cycles     = 0;
    ack_odds        = 0;
    line_level_mode = 2;
    bus_phase       = 0;
    ctl             = '0;
    ctl.step        = ST_IDLE;
    ctl.scl         = 1'b1;
    ctl.lvl         = 1'b1;
    regs.ticks      = TICKS_RESET;
    regs.limit      = LIMIT_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_directed();
    test_slow_timing();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && line_states_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
